@@ hw/rtl/cascade_pairwise_fp_sum_unit_defines.svh @@
// ----------------------------------------------------------------------------
// cascade pairwise fp sum unit assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CASCADE_PAIRWISE_FP_SUM_UNIT_DEFINES_SVH
`define CASCADE_PAIRWISE_FP_SUM_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define CPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cps same-cycle check failed");

// next-cycle implication under reset
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cps next-cycle check failed");

`endif

@@ hw/rtl/cps_pkg.sv @@
// ----------------------------------------------------------------------------
// cps_pkg
// shared constants, state types and helpers of the cascade sum unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cps_pkg;

    localparam int LEVELS = 32;
    localparam int LVL_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] POS_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ALIGN,
        A_ADD,
        A_NORM,
        A_ROUND
    } t_add_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PCHK,
        S_PADD,
        S_PWAIT,
        S_OADD,
        S_OWAIT,
        S_FSTART,
        S_FCHK,
        S_FLOAD,
        S_FADD,
        S_FWAIT,
        S_TADD,
        S_TWAIT
    } t_seq_state;

    // leading zero count of a nonzero 56-bit word
    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] r;
        r = 6'd0;
        for (int i = 0; i < 56; i++) begin
            if (v[i]) begin
                r = 6'(55 - i);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cps_ram.sv @@
// ----------------------------------------------------------------------------
// cps_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cps_fp_add.sv @@
// ----------------------------------------------------------------------------
// cps_fp_add
// multi-cycle ieee double adder, round to nearest even
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cps_fp_add
    import cps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_sum
);

    t_add_state  r_state, n_state;
    logic        r_done, n_done;
    logic [63:0] r_res, n_res;
    logic        r_sign, n_sign;
    logic        r_sub, n_sub;
    logic [11:0] r_e, n_e;
    logic [11:0] r_d, n_d;
    logic [52:0] r_mx, n_mx;
    logic [52:0] r_my, n_my;
    logic [55:0] r_mys, n_mys;
    logic [56:0] r_sum, n_sum;
    logic [55:0] r_s, n_s;
    logic        r_zero, n_zero;

    // unpack
    logic        a_nan, b_nan, a_inf, b_inf, a_big;
    logic [63:0] x, y;
    logic [10:0] ex, ey;
    // align
    logic [55:0] my_ext, sh_mask;
    // normalize
    logic [5:0]  lz, shamt;
    logic [11:0] em1;
    // round
    logic        inc;
    logic [53:0] mr;
    logic [52:0] mf;
    logic [11:0] ef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_res  <= n_res;
        r_sign <= n_sign;
        r_sub  <= n_sub;
        r_e    <= n_e;
        r_d    <= n_d;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_mys  <= n_mys;
        r_sum  <= n_sum;
        r_s    <= n_s;
        r_zero <= n_zero;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_res   = r_res;
        n_sign  = r_sign;
        n_sub   = r_sub;
        n_e     = r_e;
        n_d     = r_d;
        n_mx    = r_mx;
        n_my    = r_my;
        n_mys   = r_mys;
        n_sum   = r_sum;
        n_s     = r_s;
        n_zero  = r_zero;

        a_nan = (i_a[62:52] == EXP_MAX) && (i_a[51:0] != 52'd0);
        b_nan = (i_b[62:52] == EXP_MAX) && (i_b[51:0] != 52'd0);
        a_inf = (i_a[62:52] == EXP_MAX) && (i_a[51:0] == 52'd0);
        b_inf = (i_b[62:52] == EXP_MAX) && (i_b[51:0] == 52'd0);
        a_big = (i_a[62:0] >= i_b[62:0]);
        x     = a_big ? i_a : i_b;
        y     = a_big ? i_b : i_a;
        ex    = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        ey    = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];

        my_ext  = {r_my, 3'b000};
        sh_mask = (56'd1 << r_d[5:0]) - 56'd1;

        lz    = lzc56(r_sum[55:0]);
        em1   = r_e - 12'd1;
        shamt = ({6'd0, lz} < em1) ? lz : em1[5:0];

        inc = r_s[2] & (r_s[1] | r_s[0] | r_s[3]);
        mr  = {1'b0, r_s[55:3]} + {53'd0, inc};
        mf  = mr[53] ? mr[53:1] : mr[52:0];
        ef  = mr[53] ? r_e + 12'd1 : r_e;

        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_state = A_ALIGN;
                    if (a_nan) begin
                        n_res   = i_a | 64'h0008_0000_0000_0000;
                        n_done  = 1'b1;
                        n_state = A_IDLE;
                    end else if (b_nan) begin
                        n_res   = i_b | 64'h0008_0000_0000_0000;
                        n_done  = 1'b1;
                        n_state = A_IDLE;
                    end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
                        n_res   = DEFAULT_NAN;
                        n_done  = 1'b1;
                        n_state = A_IDLE;
                    end else if (a_inf || b_inf) begin
                        n_res   = a_inf ? i_a : i_b;
                        n_done  = 1'b1;
                        n_state = A_IDLE;
                    end
                    n_sign = x[63];
                    n_sub  = x[63] ^ y[63];
                    n_e    = {1'b0, ex};
                    n_d    = {1'b0, ex} - {1'b0, ey};
                    n_mx   = {(x[62:52] != 11'd0), x[51:0]};
                    n_my   = {(y[62:52] != 11'd0), y[51:0]};
                end
            end
            A_ALIGN: begin
                // right shift with sticky
                if (r_d >= 12'd56) begin
                    n_mys = {55'd0, (r_my != 53'd0)};
                end else begin
                    n_mys = (my_ext >> r_d[5:0]) | {55'd0, ((my_ext & sh_mask) != 56'd0)};
                end
                n_state = A_ADD;
            end
            A_ADD: begin
                if (r_sub) begin
                    n_sum = {1'b0, r_mx, 3'b000} - {1'b0, r_mys};
                end else begin
                    n_sum = {1'b0, r_mx, 3'b000} + {1'b0, r_mys};
                end
                n_state = A_NORM;
            end
            A_NORM: begin
                n_zero = (r_sum == 57'd0);
                if (r_sum[56]) begin
                    n_s = r_sum[56:1] | {55'd0, r_sum[0]};
                    n_e = r_e + 12'd1;
                end else if (r_sum != 57'd0) begin
                    n_s = r_sum[55:0] << shamt;
                    n_e = r_e - {6'd0, shamt};
                end else begin
                    n_s = 56'd0;
                end
                n_state = A_ROUND;
            end
            A_ROUND: begin
                if (r_zero) begin
                    // exact cancellation gives +0, like signs keep theirs
                    n_res = r_sub ? POS_ZERO : {r_sign, 63'd0};
                end else if (ef >= 12'd2047) begin
                    n_res = {r_sign, EXP_MAX, 52'd0};
                end else begin
                    n_res = {r_sign, (mf[52] ? ef[10:0] : 11'd0), mf[51:0]};
                end
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_sum  = r_res;

endmodule

@@ hw/rtl/cascade_pairwise_fp_sum_unit.sv @@
// ----------------------------------------------------------------------------
// cascade pairwise fp sum unit
// pairwise cascade summation of a stream of ieee doubles
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// term      in         i_valid / o_ready   i_term_value[63:0], i_last_term
// sum       out        o_valid / i_ready   o_sum_value[63:0]
//
// a term that finds level 0 empty is written there (S_PCHK); each occupied
// level it carries through is read from ram and added in the shared adder
// (S_PADD, S_PWAIT); the flush on a last term walks the levels once, stepping
// over empty levels, loading the first occupied one (S_FLOAD), adding it into
// each occupied level above (S_FADD, S_FWAIT), then into the overflow total
// reset leaves every level empty and the overflow total at +0
// a finished sum waits in the output register while new terms are taken;
// only the final step of the next flush waits for it to be delivered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascade_pairwise_fp_sum_unit
    import cps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_term_value,
    input  logic        i_last_term,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_sum_value
);

    t_seq_state        r_state, n_state;
    logic [LVL_AW-1:0] r_idx, n_idx;
    logic [63:0]       r_c, n_c;        // carry / current level value
    logic              r_cv, n_cv;      // r_c holds level r_idx during flush
    logic              r_last, n_last;
    logic [LEVELS-1:0] r_empty, n_empty;
    logic [63:0]       r_ovf, n_ovf;    // overflow accumulator
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_out, n_out;

    logic              in_req;
    logic [LVL_AW-1:0] idx1;
    logic              top;

    // level storage
    logic              ram_we, ram_re;
    logic [LVL_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]       ram_rdata;

    // shared adder
    logic              add_start, add_done;
    logic [63:0]       add_a, add_b, add_sum;

    cps_ram #(
        .WIDTH (64),
        .DEPTH (LEVELS)
    ) u_levels (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_c),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cps_fp_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (add_start),
        .i_a     (add_a),
        .i_b     (add_b),
        .o_done  (add_done),
        .o_sum   (add_sum)
    );

    assign in_req = i_valid && o_ready;
    assign idx1   = r_idx + 1'b1;
    assign top    = (r_idx == LVL_AW'(LEVELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_empty     <= '1;
            r_ovf       <= POS_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_empty     <= n_empty;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_c    <= n_c;
        r_cv   <= n_cv;
        r_last <= n_last;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_c         = r_c;
        n_cv        = r_cv;
        n_last      = r_last;
        n_empty     = r_empty;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_idx;
        ram_raddr   = r_idx;
        add_start   = 1'b0;
        add_a       = ram_rdata;
        add_b       = r_c;
        o_ready     = 1'b0;

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (in_req) begin
                    n_c     = i_term_value;
                    n_last  = i_last_term;
                    n_idx   = '0;
                    n_state = S_PCHK;
                end
            end
            // carry walk: an empty level stops the carry
            S_PCHK: begin
                if (r_empty[r_idx]) begin
                    ram_we           = 1'b1;
                    n_empty[r_idx]   = 1'b0;
                    n_state          = r_last ? S_FSTART : S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_PADD;
                end
            end
            S_PADD: begin
                add_start = 1'b1;
                n_state   = S_PWAIT;
            end
            S_PWAIT: begin
                if (add_done) begin
                    n_c            = add_sum;
                    n_empty[r_idx] = 1'b1;
                    if (top) begin
                        n_state = S_OADD;
                    end else begin
                        n_idx   = idx1;
                        n_state = S_PCHK;
                    end
                end
            end
            // carry out of the top level
            S_OADD: begin
                add_start = 1'b1;
                add_a     = r_ovf;
                n_state   = S_OWAIT;
            end
            S_OWAIT: begin
                if (add_done) begin
                    n_ovf   = add_sum;
                    n_state = r_last ? S_FSTART : S_IDLE;
                end
            end
            S_FSTART: begin
                n_idx   = '0;
                n_cv    = 1'b0;
                n_state = S_FCHK;
            end
            // flush: fold each occupied level into the next one up
            S_FCHK: begin
                if (r_empty[r_idx]) begin
                    n_cv = 1'b0;
                    if (top) begin
                        // hold here until the previous sum has left
                        if (!r_out_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_ovf;
                            n_empty     = '1;
                            n_ovf       = POS_ZERO;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_idx = idx1;
                    end
                end else if (!r_cv) begin
                    ram_re  = 1'b1;
                    n_state = S_FLOAD;
                end else if (top) begin
                    n_state = S_TADD;
                end else if (r_empty[idx1]) begin
                    // level moves up unchanged, value stays in r_c
                    n_empty[idx1] = 1'b0;
                    n_idx         = idx1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx1;
                    n_state   = S_FADD;
                end
            end
            S_FLOAD: begin
                n_c     = ram_rdata;
                n_cv    = 1'b1;
                n_state = S_FCHK;
            end
            S_FADD: begin
                add_start = 1'b1;
                n_state   = S_FWAIT;
            end
            S_FWAIT: begin
                if (add_done) begin
                    n_c     = add_sum;
                    n_cv    = 1'b1;
                    n_idx   = idx1;
                    n_state = S_FCHK;
                end
            end
            // total = overflow + top level, started once the output is free
            S_TADD: begin
                add_a = r_ovf;
                if (!r_out_valid) begin
                    add_start = 1'b1;
                    n_state   = S_TWAIT;
                end
            end
            S_TWAIT: begin
                if (add_done) begin
                    n_out_valid = 1'b1;
                    n_out       = add_sum;
                    n_empty     = '1;
                    n_ovf       = POS_ZERO;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_sum_value = r_out;

endmodule

@@ hw/rtl/cps_checker.sv @@
// ----------------------------------------------------------------------------
// cps_checker
// port-level checks of the cascade sum unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascade_pairwise_fp_sum_unit_defines.svh"

module cps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [63:0] i_term_value,
    input logic        i_last_term,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_sum_value
);

    // a stalled result holds
    `CPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sum_value))

    // a request keeps the unit busy the next cycle
    `CPS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // a presented result is fully known
    `CPS_ASSERT_IMPL(a_result_known, i_clk, i_rst_n, o_valid, !$isunknown(o_sum_value))

    // one result per series
    `CPS_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_valid && i_ready, !o_valid)

endmodule

bind cascade_pairwise_fp_sum_unit cps_checker u_cps_checker (.*);
